// ===== rtl/c_sts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C subset token scanner package
// Shared types, token kind codes and character class helpers.
// ----------------------------------------------------------------------------
package c_sts_pkg;

    localparam int DEF_POSITION_BITS   = 16;
    localparam int DEF_MAX_FRAC_DIGITS = 9;

    localparam int TOKEN_POS_BITS = 16;
    localparam int INT_BITS       = 32;
    localparam int FRAC_BITS      = 30;
    localparam int FCOUNT_BITS    = 4;
    localparam int WORD_BITS      = 48;
    localparam int WLEN_BITS      = 3;

    // Result queue depth; must be a power of two and at least two.
    localparam int QUEUE_DEPTH = 4;

    // Token kinds.
    localparam logic [4:0] KIND_KW_INT    = 5'd0;
    localparam logic [4:0] KIND_KW_CHAR   = 5'd1;
    localparam logic [4:0] KIND_KW_FLOAT  = 5'd2;
    localparam logic [4:0] KIND_KW_RETURN = 5'd3;
    localparam logic [4:0] KIND_KW_IF     = 5'd4;
    localparam logic [4:0] KIND_KW_ELSE   = 5'd5;
    localparam logic [4:0] KIND_KW_FOR    = 5'd6;
    localparam logic [4:0] KIND_KW_WHILE  = 5'd7;
    localparam logic [4:0] KIND_IDENT     = 5'd8;
    localparam logic [4:0] KIND_INTNUM    = 5'd9;
    localparam logic [4:0] KIND_FLOATNUM  = 5'd10;
    localparam logic [4:0] KIND_ASSIGN    = 5'd11;
    localparam logic [4:0] KIND_LESS      = 5'd12;
    localparam logic [4:0] KIND_GREATER   = 5'd13;
    localparam logic [4:0] KIND_PLUS      = 5'd14;
    localparam logic [4:0] KIND_MINUS     = 5'd15;
    localparam logic [4:0] KIND_STAR      = 5'd16;
    localparam logic [4:0] KIND_SLASH     = 5'd17;
    localparam logic [4:0] KIND_LPAREN    = 5'd18;
    localparam logic [4:0] KIND_RPAREN    = 5'd19;
    localparam logic [4:0] KIND_LBRACE    = 5'd20;
    localparam logic [4:0] KIND_RBRACE    = 5'd21;
    localparam logic [4:0] KIND_SEMI      = 5'd22;
    localparam logic [4:0] KIND_COMMA     = 5'd23;
    localparam logic [4:0] KIND_EOF       = 5'd24;
    localparam logic [4:0] KIND_ERROR     = 5'd25;

    // Characters with a role of their own in the scanner.
    localparam logic [7:0] CH_UNDERSCORE = "_";
    localparam logic [7:0] CH_SLASH      = "/";
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_POINT      = ".";

    // Keyword spellings, right aligned in the word buffer.
    localparam logic [WORD_BITS-1:0] KW_INT    = {24'h0, "int"};
    localparam logic [WORD_BITS-1:0] KW_CHAR   = {16'h0, "char"};
    localparam logic [WORD_BITS-1:0] KW_FLOAT  = {8'h0, "float"};
    localparam logic [WORD_BITS-1:0] KW_RETURN = "return";
    localparam logic [WORD_BITS-1:0] KW_IF     = {32'h0, "if"};
    localparam logic [WORD_BITS-1:0] KW_ELSE   = {16'h0, "else"};
    localparam logic [WORD_BITS-1:0] KW_FOR    = {24'h0, "for"};
    localparam logic [WORD_BITS-1:0] KW_WHILE  = {8'h0, "while"};

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_source;
    } t_char_item;

    typedef struct packed {
        logic [4:0]                token_kind;
        logic [INT_BITS-1:0]       int_value;
        logic [FRAC_BITS-1:0]      frac_digits;
        logic [FCOUNT_BITS-1:0]    frac_count;
        logic                      overflow;
        logic [TOKEN_POS_BITS-1:0] token_line;
        logic [TOKEN_POS_BITS-1:0] token_column;
        logic                      last_of_run;
    } t_token;

    // Up to two tokens pushed into the result queue together, in order.
    typedef struct packed {
        logic   first_valid;
        logic   second_valid;
        t_token first;
        t_token second;
    } t_push;

    typedef struct packed {
        logic                             room_for_two;
        logic [$clog2(QUEUE_DEPTH+1)-1:0] count;
    } t_queue_status;

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || (c == 8'h09) || (c == CH_NEWLINE) || (c == 8'h0B) ||
               (c == 8'h0C) || (c == 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
               (c == CH_UNDERSCORE);
    endfunction

    function automatic logic [4:0] symbol_kind(input logic [7:0] c);
        logic [4:0] kind;
        kind = KIND_ERROR;
        case (c)
            "=":     kind = KIND_ASSIGN;
            "<":     kind = KIND_LESS;
            ">":     kind = KIND_GREATER;
            "+":     kind = KIND_PLUS;
            "-":     kind = KIND_MINUS;
            "*":     kind = KIND_STAR;
            "/":     kind = KIND_SLASH;
            "(":     kind = KIND_LPAREN;
            ")":     kind = KIND_RPAREN;
            "{":     kind = KIND_LBRACE;
            "}":     kind = KIND_RBRACE;
            ";":     kind = KIND_SEMI;
            ",":     kind = KIND_COMMA;
            default: kind = KIND_ERROR;
        endcase
        return kind;
    endfunction

    // Whole-word keyword match; a length of seven means longer than six.
    function automatic logic [4:0] word_kind(input logic [WORD_BITS-1:0] buf_w,
                                             input logic [WLEN_BITS-1:0] len);
        logic [4:0] kind;
        kind = KIND_IDENT;
        if (len == 3'd3 && buf_w == KW_INT)         kind = KIND_KW_INT;
        else if (len == 3'd4 && buf_w == KW_CHAR)   kind = KIND_KW_CHAR;
        else if (len == 3'd5 && buf_w == KW_FLOAT)  kind = KIND_KW_FLOAT;
        else if (len == 3'd6 && buf_w == KW_RETURN) kind = KIND_KW_RETURN;
        else if (len == 3'd2 && buf_w == KW_IF)     kind = KIND_KW_IF;
        else if (len == 3'd4 && buf_w == KW_ELSE)   kind = KIND_KW_ELSE;
        else if (len == 3'd3 && buf_w == KW_FOR)    kind = KIND_KW_FOR;
        else if (len == 3'd5 && buf_w == KW_WHILE)  kind = KIND_KW_WHILE;
        return kind;
    endfunction

    function automatic t_token make_token(input logic [4:0]                kind,
                                          input logic [INT_BITS-1:0]       iv,
                                          input logic [FRAC_BITS-1:0]      fd,
                                          input logic [FCOUNT_BITS-1:0]    fc,
                                          input logic                      ov,
                                          input logic [TOKEN_POS_BITS-1:0] line,
                                          input logic [TOKEN_POS_BITS-1:0] col);
        t_token t;
        t.token_kind   = kind;
        t.int_value    = iv;
        t.frac_digits  = fd;
        t.frac_count   = fc;
        t.overflow     = ov;
        t.token_line   = line;
        t.token_column = col;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

endpackage

// ===== rtl/c_sts_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C subset token scanner: scan state and per-character step
// Holds the scan mode, number and word accumulators and source position, and
// turns one character into up to two tokens combinationally.
// ----------------------------------------------------------------------------
module c_sts_scan #(
    parameter int POSITION_BITS   = c_sts_pkg::DEF_POSITION_BITS,
    parameter int MAX_FRAC_DIGITS = c_sts_pkg::DEF_MAX_FRAC_DIGITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  c_sts_pkg::t_char_item i_item,
    output c_sts_pkg::t_push      o_push
);

    localparam int IB = c_sts_pkg::INT_BITS;
    localparam int FB = c_sts_pkg::FRAC_BITS;
    localparam int CB = c_sts_pkg::FCOUNT_BITS;
    localparam int WB = c_sts_pkg::WORD_BITS;
    localparam int LB = c_sts_pkg::WLEN_BITS;
    localparam int TP = c_sts_pkg::TOKEN_POS_BITS;
    localparam logic [CB-1:0] FRAC_LIMIT = CB'(MAX_FRAC_DIGITS);

    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_WORD    = 6'b000010,
        MODE_INT     = 6'b000100,
        MODE_FRAC    = 6'b001000,
        MODE_SLASH   = 6'b010000,
        MODE_COMMENT = 6'b100000
    } t_mode;

    t_mode                    r_mode, n_mode;
    logic [IB-1:0]            r_int, n_int;
    logic [FB-1:0]            r_frac, n_frac;
    logic [CB-1:0]            r_fcnt, n_fcnt;
    logic                     r_sat, n_sat;
    logic [WB-1:0]            r_wbuf, n_wbuf;
    logic [LB-1:0]            r_wlen, n_wlen;
    logic [POSITION_BITS-1:0] r_line, n_line;
    logic [POSITION_BITS-1:0] r_col, n_col;
    logic [POSITION_BITS-1:0] r_sline, n_sline;
    logic [POSITION_BITS-1:0] r_scol, n_scol;

    logic [7:0]         c;
    logic [3:0]         digit;
    logic [IB+3:0]      int_next;
    logic [FB-1:0]      frac_next;
    logic               do_flush;
    logic               consumed;
    logic               flush_valid;
    c_sts_pkg::t_token  flush_tok;
    logic               other_valid;
    c_sts_pkg::t_token  other_tok;

    function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] v);
        return (v == {POSITION_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

    assign c     = i_item.char_byte;
    assign digit = c[3:0];

    // Times ten as two shifts and an add, plus the new digit.
    assign int_next  = {1'b0, r_int, 3'b000} + {3'b000, r_int, 1'b0} + {{IB{1'b0}}, digit};
    assign frac_next = FB'({r_frac, 3'b000} + {2'b00, r_frac, 1'b0} +
                           {{(FB-1){1'b0}}, digit});

    // The pending token as it stands before this character.
    always_comb begin
        flush_valid = 1'b0;
        flush_tok   = c_sts_pkg::make_token(c_sts_pkg::KIND_SLASH, '0, '0, '0, 1'b0,
                                            TP'(r_sline), TP'(r_scol));
        unique case (r_mode)
            MODE_WORD: begin
                flush_valid = 1'b1;
                flush_tok.token_kind = c_sts_pkg::word_kind(r_wbuf, r_wlen);
            end
            MODE_INT: begin
                flush_valid = 1'b1;
                flush_tok.token_kind = c_sts_pkg::KIND_INTNUM;
                flush_tok.int_value  = r_int;
                flush_tok.overflow   = r_sat;
            end
            MODE_FRAC: begin
                flush_valid = 1'b1;
                flush_tok.token_kind  = c_sts_pkg::KIND_FLOATNUM;
                flush_tok.int_value   = r_int;
                flush_tok.frac_digits = r_frac;
                flush_tok.frac_count  = r_fcnt;
                flush_tok.overflow    = r_sat;
            end
            MODE_SLASH: begin
                flush_valid = 1'b1;
            end
            default: begin
                flush_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_mode   = r_mode;
        n_int    = r_int;
        n_frac   = r_frac;
        n_fcnt   = r_fcnt;
        n_sat    = r_sat;
        n_wbuf   = r_wbuf;
        n_wlen   = r_wlen;
        n_line   = r_line;
        n_col    = r_col;
        n_sline  = r_sline;
        n_scol   = r_scol;
        do_flush = 1'b0;
        consumed = 1'b0;
        other_valid = 1'b0;
        other_tok   = c_sts_pkg::make_token(c_sts_pkg::KIND_EOF, '0, '0, '0, 1'b0,
                                            TP'(r_line), TP'(pos_inc(r_col)));

        if (i_item.end_of_source) begin
            do_flush    = 1'b1;
            n_mode      = MODE_IDLE;
            other_valid = 1'b1;
        end else begin
            if (c == c_sts_pkg::CH_NEWLINE) begin
                n_line = pos_inc(r_line);
                n_col  = '0;
            end else begin
                n_col = pos_inc(r_col);
            end

            unique case (r_mode)
                MODE_COMMENT: begin
                    consumed = 1'b1;
                    if (c == c_sts_pkg::CH_NEWLINE) begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_SLASH: begin
                    if (c == c_sts_pkg::CH_SLASH) begin
                        consumed = 1'b1;
                        n_mode   = MODE_COMMENT;
                    end
                end
                MODE_WORD: begin
                    if (c_sts_pkg::is_word(c)) begin
                        consumed = 1'b1;
                        if (r_wlen < 3'd6) begin
                            n_wbuf = {r_wbuf[WB-9:0], c};
                            n_wlen = r_wlen + 3'd1;
                        end else begin
                            n_wlen = 3'd7;
                        end
                    end
                end
                MODE_INT: begin
                    if (c_sts_pkg::is_digit(c)) begin
                        consumed = 1'b1;
                        if (int_next[IB+3:IB] != 4'b0000) begin
                            n_int = {IB{1'b1}};
                            n_sat = 1'b1;
                        end else begin
                            n_int = int_next[IB-1:0];
                        end
                    end else if (c == c_sts_pkg::CH_POINT) begin
                        consumed = 1'b1;
                        n_mode   = MODE_FRAC;
                    end
                end
                MODE_FRAC: begin
                    if (c_sts_pkg::is_digit(c)) begin
                        consumed = 1'b1;
                        if (r_fcnt < FRAC_LIMIT) begin
                            n_frac = frac_next;
                            n_fcnt = r_fcnt + 1'b1;
                        end
                    end
                end
                default: begin
                    consumed = 1'b0;
                end
            endcase

            if (!consumed) begin
                do_flush = 1'b1;
                n_mode   = MODE_IDLE;
                if (c_sts_pkg::is_space(c)) begin
                    n_mode = MODE_IDLE;
                end else if (c_sts_pkg::is_word(c)) begin
                    n_mode  = MODE_WORD;
                    n_wbuf  = {{(WB-8){1'b0}}, c};
                    n_wlen  = 3'd1;
                    n_sline = n_line;
                    n_scol  = n_col;
                end else if (c_sts_pkg::is_digit(c)) begin
                    n_mode  = MODE_INT;
                    n_int   = {{(IB-4){1'b0}}, digit};
                    n_frac  = '0;
                    n_fcnt  = '0;
                    n_sat   = 1'b0;
                    n_sline = n_line;
                    n_scol  = n_col;
                end else if (c == c_sts_pkg::CH_SLASH) begin
                    n_mode  = MODE_SLASH;
                    n_sline = n_line;
                    n_scol  = n_col;
                end else begin
                    other_valid = 1'b1;
                    other_tok   = c_sts_pkg::make_token(c_sts_pkg::symbol_kind(c), '0, '0,
                                                        '0, 1'b0, TP'(n_line), TP'(n_col));
                end
            end
        end
    end

    // Pack the results in order; the last one of the item carries the flag.
    always_comb begin
        logic fv;
        fv = do_flush && flush_valid;
        o_push = '0;
        if (i_step) begin
            if (fv) begin
                o_push.first_valid  = 1'b1;
                o_push.first        = flush_tok;
                o_push.second_valid = other_valid;
                o_push.second       = other_tok;
                o_push.first.last_of_run  = !other_valid;
                o_push.second.last_of_run = 1'b1;
            end else begin
                o_push.first_valid = other_valid;
                o_push.first       = other_tok;
                o_push.first.last_of_run = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_int   <= '0;
            r_frac  <= '0;
            r_fcnt  <= '0;
            r_sat   <= 1'b0;
            r_wbuf  <= '0;
            r_wlen  <= '0;
            r_line  <= POSITION_BITS'(1);
            r_col   <= '0;
            r_sline <= POSITION_BITS'(1);
            r_scol  <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_int   <= n_int;
            r_frac  <= n_frac;
            r_fcnt  <= n_fcnt;
            r_sat   <= n_sat;
            r_wbuf  <= n_wbuf;
            r_wlen  <= n_wlen;
            r_line  <= n_line;
            r_col   <= n_col;
            r_sline <= n_sline;
            r_scol  <= n_scol;
        end
    end

endmodule

// ===== rtl/c_sts_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C subset token scanner: result queue
// Small queue that takes up to two tokens per cycle and hands out one.
// ----------------------------------------------------------------------------
module c_sts_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  c_sts_pkg::t_push         i_push,
    input  logic                     i_pop,
    output logic                     o_valid,
    output c_sts_pkg::t_token        o_token,
    output c_sts_pkg::t_queue_status o_status
);

    localparam int DEPTH = c_sts_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    c_sts_pkg::t_token r_mem [DEPTH];
    logic [PW-1:0]     r_head;
    logic [PW-1:0]     r_tail;
    logic [CW-1:0]     r_count;
    logic [1:0]        push_n;
    logic              pop;

    assign push_n = {1'b0, i_push.first_valid} + {1'b0, i_push.second_valid};
    assign pop    = i_pop && (r_count != '0);

    assign o_valid               = (r_count != '0);
    assign o_token               = r_mem[r_head];
    assign o_status.count        = r_count;
    assign o_status.room_for_two = (r_count <= CW'(DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= r_head + PW'(pop);
            r_tail  <= r_tail + PW'(push_n);
            r_count <= r_count + CW'(push_n) - CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first_valid) begin
            r_mem[r_tail] <= i_push.first;
        end
        if (i_push.second_valid) begin
            r_mem[PW'(r_tail + 1'b1)] <= i_push.second;
        end
    end

endmodule

// ===== rtl/c_subset_token_scanner_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C subset token scanner
// Streaming lexer: one source character in, up to two tokens out.
// ----------------------------------------------------------------------------
// One character (or the end marker) is accepted per clock cycle. It is
// registered, scanned from the input register once the queue has room and
// its tokens, at most two, go into a four-entry result queue. The input
// stalls while the registered character waits for the queue to hold two free
// entries; since a character causes two tokens only when it ends a pending
// token and is itself a symbol or the end marker, the rate stays at one
// character per cycle whenever the output side takes one token per cycle.
// No clearing pass follows reset.
module c_subset_token_scanner_top #(
    parameter int POSITION_BITS   = c_sts_pkg::DEF_POSITION_BITS,
    parameter int MAX_FRAC_DIGITS = c_sts_pkg::DEF_MAX_FRAC_DIGITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  c_sts_pkg::t_char_item i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output c_sts_pkg::t_token     o_token
);

    logic                     r_in_valid;
    c_sts_pkg::t_char_item    r_in;
    logic                     step;
    c_sts_pkg::t_push         push;
    c_sts_pkg::t_queue_status q_status;

    assign step    = r_in_valid && q_status.room_for_two;
    assign o_stall = r_in_valid && !q_status.room_for_two;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in <= i_item;
        end
    end

    c_sts_scan #(
        .POSITION_BITS  (POSITION_BITS),
        .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
    ) u_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (step),
        .i_item (r_in),
        .o_push (push)
    );

    c_sts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_stall),
        .o_valid (o_valid),
        .o_token (o_token),
        .o_status(q_status)
    );

    // The queue never holds more tokens than it has entries.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= ($clog2(c_sts_pkg::QUEUE_DEPTH + 1))'(c_sts_pkg::QUEUE_DEPTH))
        else $error("result queue overfilled");

    // A character held back by a queue without room for two tokens stays in the input register.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> r_in_valid && $stable(r_in))
        else $error("held character lost");

    // An end marker always closes its run of tokens.
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token.token_kind == c_sts_pkg::KIND_EOF) |-> o_token.last_of_run)
        else $error("EOF token not last of run");

    // Nothing is pushed unless the queue had room for a full pair.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.first_valid |-> q_status.room_for_two)
        else $error("push without room");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C subset token scanner testbench
// Feeds source characters through the valid/stall channel and checks every
// token against a scanner model kept in the bench, or against the token
// written out for a typed row. A short table of directed characters comes
// first, then random C-like text with comments, numbers, keywords and noise.
// ----------------------------------------------------------------------------
module tb;
    import c_sts_pkg::*;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1000;
    localparam int FRAC_KEEP    = DEF_MAX_FRAC_DIGITS;

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_WORD, SCAN_INT, SCAN_FRAC, SCAN_SLASH, SCAN_COMMENT
    } scan_mode_t;

    typedef struct {
        t_char_item item;
        bit         typed;
        t_token     tok;
    } dir_row_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_char_item i_item;
    logic       o_valid;
    logic       i_stall;
    t_token     o_token;

    c_subset_token_scanner_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_token (o_token)
    );

    // Scanner state as seen by the bench.
    scan_mode_t  scan_mode;
    logic [31:0] num_acc;
    logic [29:0] frac_acc;
    logic [3:0]  frac_cnt;
    logic        num_sat;
    logic [47:0] word_bits;
    logic [2:0]  word_len;
    logic [15:0] cur_line;
    logic [15:0] cur_col;
    logic [15:0] start_ln;
    logic [15:0] start_col;

    t_token     step_tokens[$];
    t_token     tokens_due[$];
    dir_row_t   dir_rows[$];
    t_char_item source_text[$];

    int error_count = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    bit hold_off_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d tokens outstanding", $time, tokens_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic bit blank_char(input logic [7:0] c);
        return c == " " || c == 8'h09 || c == CH_NEWLINE || c == 8'h0B ||
               c == 8'h0C || c == 8'h0D;
    endfunction

    function automatic bit digit_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit word_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [4:0] symbol_code(input logic [7:0] c);
        string ops;
        ops = "=<>+-*/(){};,";
        for (int i = 0; i < ops.len(); i++)
            if (ops[i] == c) return KIND_ASSIGN + 5'(i);
        return KIND_ERROR;
    endfunction

    function automatic bit spelled(input string s);
        if (s.len() != word_len) return 1'b0;
        for (int i = 0; i < s.len(); i++)
            if (word_bits[8*(word_len-1-i) +: 8] != s[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [4:0] keyword_kind();
        if (spelled("int"))    return KIND_KW_INT;
        if (spelled("char"))   return KIND_KW_CHAR;
        if (spelled("float"))  return KIND_KW_FLOAT;
        if (spelled("return")) return KIND_KW_RETURN;
        if (spelled("if"))     return KIND_KW_IF;
        if (spelled("else"))   return KIND_KW_ELSE;
        if (spelled("for"))    return KIND_KW_FOR;
        if (spelled("while"))  return KIND_KW_WHILE;
        return KIND_IDENT;
    endfunction

    function automatic void note_token(input logic [4:0] kind, input logic [31:0] iv,
                                       input logic [29:0] fd, input logic [3:0] fc,
                                       input logic ov, input logic [15:0] ln,
                                       input logic [15:0] col);
        t_token t;
        t.token_kind   = kind;
        t.int_value    = iv;
        t.frac_digits  = fd;
        t.frac_count   = fc;
        t.overflow     = ov;
        t.token_line   = ln;
        t.token_column = col;
        t.last_of_run  = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void reset_scanner();
        scan_mode = SCAN_IDLE;
        num_acc   = '0;
        frac_acc  = '0;
        frac_cnt  = '0;
        num_sat   = 1'b0;
        word_bits = '0;
        word_len  = '0;
        cur_line  = 16'd1;
        cur_col   = '0;
        start_ln  = 16'd1;
        start_col = '0;
    endfunction

    // Emits the token that is being collected, if any, and returns to idle.
    function automatic void close_token();
        case (scan_mode)
            SCAN_WORD:  note_token(keyword_kind(), 0, 0, 0, 0, start_ln, start_col);
            SCAN_INT:   note_token(KIND_INTNUM, num_acc, 0, 0, num_sat, start_ln, start_col);
            SCAN_FRAC:  note_token(KIND_FLOATNUM, num_acc, frac_acc, frac_cnt, num_sat,
                                   start_ln, start_col);
            SCAN_SLASH: note_token(KIND_SLASH, 0, 0, 0, 0, start_ln, start_col);
            default: ;
        endcase
        scan_mode = SCAN_IDLE;
    endfunction

    // Works out the tokens that one accepted transaction causes.
    function automatic void scan_char(input t_char_item it);
        logic [7:0]  c;
        logic [63:0] wide;
        bit          taken;
        c = it.char_byte;
        taken = 1'b0;
        step_tokens.delete();
        if (it.end_of_source) begin
            close_token();
            note_token(KIND_EOF, 0, 0, 0, 0, cur_line, bump(cur_col));
        end else begin
            if (c == CH_NEWLINE) begin
                cur_line = bump(cur_line);
                cur_col  = '0;
            end else begin
                cur_col = bump(cur_col);
            end
            case (scan_mode)
                SCAN_COMMENT: begin
                    taken = 1'b1;
                    if (c == CH_NEWLINE) scan_mode = SCAN_IDLE;
                end
                SCAN_SLASH: if (c == CH_SLASH) begin
                    scan_mode = SCAN_COMMENT;
                    taken = 1'b1;
                end
                SCAN_WORD: if (word_char(c)) begin
                    taken = 1'b1;
                    if (word_len < 3'd6) begin
                        word_bits = {word_bits[39:0], c};
                        word_len  = word_len + 3'd1;
                    end else begin
                        word_len = 3'd7;
                    end
                end
                SCAN_INT: if (digit_char(c)) begin
                    taken = 1'b1;
                    wide = 64'(num_acc) * 64'd10 + 64'(c) - 64'd48;
                    if (wide > 64'hFFFF_FFFF) begin
                        num_acc = '1;
                        num_sat = 1'b1;
                    end else begin
                        num_acc = wide[31:0];
                    end
                end else if (c == CH_POINT) begin
                    scan_mode = SCAN_FRAC;
                    taken = 1'b1;
                end
                SCAN_FRAC: if (digit_char(c)) begin
                    taken = 1'b1;
                    // Digits past the kept count are dropped, not rounded.
                    if (frac_cnt < 4'(FRAC_KEEP)) begin
                        frac_acc = 30'(32'(frac_acc) * 32'd10 + 32'(c) - 32'd48);
                        frac_cnt = frac_cnt + 4'd1;
                    end
                end
                default: ;
            endcase
            if (!taken) begin
                close_token();
                if (!blank_char(c)) begin
                    if (word_char(c)) begin
                        scan_mode = SCAN_WORD;
                        word_bits = 48'(c);
                        word_len  = 3'd1;
                        start_ln  = cur_line;
                        start_col = cur_col;
                    end else if (digit_char(c)) begin
                        scan_mode = SCAN_INT;
                        num_acc   = 32'(c) - 32'd48;
                        frac_acc  = '0;
                        frac_cnt  = '0;
                        num_sat   = 1'b0;
                        start_ln  = cur_line;
                        start_col = cur_col;
                    end else if (c == CH_SLASH) begin
                        scan_mode = SCAN_SLASH;
                        start_ln  = cur_line;
                        start_col = cur_col;
                    end else begin
                        note_token(symbol_code(c), 0, 0, 0, 0, cur_line, cur_col);
                    end
                end
            end
        end
        if (step_tokens.size() != 0)
            step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
    endfunction

    function automatic void row(input logic [7:0] c);
        dir_row_t r;
        r.item.char_byte     = c;
        r.item.end_of_source = 1'b0;
        r.typed = 1'b0;
        r.tok   = '0;
        dir_rows.push_back(r);
    endfunction

    // A row whose single token is written out here rather than predicted.
    function automatic void typed_row(input logic [7:0] c, input logic eos,
                                      input logic [4:0] kind, input logic [15:0] ln,
                                      input logic [15:0] col);
        dir_row_t r;
        r.item.char_byte     = c;
        r.item.end_of_source = eos;
        r.typed = 1'b1;
        r.tok   = '0;
        r.tok.token_kind   = kind;
        r.tok.token_line   = ln;
        r.tok.token_column = col;
        r.tok.last_of_run  = 1'b1;
        dir_rows.push_back(r);
    endfunction

    function automatic void push_char(input logic [7:0] c);
        t_char_item it;
        it.char_byte     = c;
        it.end_of_source = 1'b0;
        source_text.push_back(it);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endfunction

    function automatic void push_eof();
        t_char_item it;
        it.char_byte     = 8'($urandom_range(0, 255));
        it.end_of_source = 1'b1;
        source_text.push_back(it);
    endfunction

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 6))
            0:       return 8'h09;
            1:       return 8'h0B;
            2:       return 8'h0C;
            3:       return 8'h0D;
            4:       return CH_NEWLINE;
            default: return " ";
        endcase
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'($urandom_range(48, 57));
    endfunction

    function automatic logic [7:0] random_letter();
        string letters;
        letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        return letters[$urandom_range(0, 52)];
    endfunction

    function automatic string keyword_text(input int k);
        case (k)
            0:       return "int";
            1:       return "char";
            2:       return "float";
            3:       return "return";
            4:       return "if";
            5:       return "else";
            6:       return "for";
            default: return "while";
        endcase
    endfunction

    // Mostly well-formed C-like lexemes, with noise and broken numbers mixed in.
    function automatic void compose_random_text();
        int         pick;
        string      kw;
        string      ops;
        logic [7:0] b;
        ops = "=<>+-*/(){};,";
        while (source_text.size() < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                kw = keyword_text($urandom_range(0, 7));
                case ($urandom_range(0, 4))
                    0: begin
                        push_text(kw);
                        push_char(random_letter());
                    end
                    1: begin
                        push_char(kw[0] - 8'd32);
                        push_text(kw.substr(1, kw.len() - 1));
                    end
                    2: push_text(kw.substr(0, kw.len() - 2));
                    default: push_text(kw);
                endcase
            end else if (pick < 30) begin
                repeat (($urandom_range(0, 3) == 0) ? $urandom_range(6, 7) : $urandom_range(1, 10))
                    push_char(random_letter());
            end else if (pick < 44) begin
                case ($urandom_range(0, 6))
                    0: push_text("4294967295");
                    1: push_text("4294967296");
                    2: repeat ($urandom_range(10, 13)) push_char(random_digit());
                    default: repeat ($urandom_range(1, 5)) push_char(random_digit());
                endcase
            end else if (pick < 54) begin
                repeat ($urandom_range(1, 3)) push_char(random_digit());
                push_char(CH_POINT);
                repeat ($urandom_range(0, 12)) push_char(random_digit());
            end else if (pick < 69) begin
                push_char(ops[$urandom_range(0, 12)]);
            end else if (pick < 74) begin
                push_text("//");
                repeat ($urandom_range(0, 8)) begin
                    b = 8'($urandom_range(0, 255));
                    push_char((b == CH_NEWLINE) ? 8'h23 : b);
                end
                push_char(CH_NEWLINE);
            end else if (pick < 83) begin
                push_char(random_blank());
            end else if (pick < 90) begin
                push_char(8'($urandom_range(0, 255)));
            end else if (pick < 94) begin
                case ($urandom_range(0, 2))
                    0:       push_text("1.2.3");
                    1:       push_text("./");
                    default: push_text("3..4");
                endcase
            end else if (pick < 97) begin
                push_eof();
            end else begin
                push_char(8'($urandom_range(32, 126)));
            end
            if ($urandom_range(0, 1) == 1) push_char(random_blank());
        end
        push_eof();
    endfunction

    // Sends one transaction in the current burst and predicts its tokens on
    // the edge where it is taken.
    task automatic send_item(input t_char_item it, input bit typed, input t_token typed_tok);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_item  <= it;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        scan_char(it);
        if (typed) begin
            tokens_due.push_back(typed_tok);
        end else begin
            foreach (step_tokens[k]) tokens_due.push_back(step_tokens[k]);
        end
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_token want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (tokens_due.size() == 0) begin
                error_count++;
                $display("%0t: unexpected token: expected none, actual %p", $time, o_token);
            end else begin
                want = tokens_due.pop_front();
                check_field("token_kind", want.token_kind, o_token.token_kind);
                check_field("int_value", want.int_value, o_token.int_value);
                check_field("frac_digits", want.frac_digits, o_token.frac_digits);
                check_field("frac_count", want.frac_count, o_token.frac_count);
                check_field("overflow", want.overflow, o_token.overflow);
                check_field("token_line", want.token_line, o_token.token_line);
                check_field("token_column", want.token_column, o_token.token_column);
                check_field("last_of_run", want.last_of_run, o_token.last_of_run);
            end
        end
    end

    // Output side: stall density changes from stretch to stretch, and one
    // long hold-off lets the scanner fill up and push back on its input.
    initial begin
        int stretch_left;
        int stall_pct;
        stretch_left = 0;
        stall_pct = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(10, 80);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            stretch_left--;
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        reset_scanner();

        // Extremes of the character byte, a point with no digits before it,
        // keyword followed directly by a symbol, a trailing point, a comment,
        // a lone slash, a second point after a fraction, and the end marker.
        typed_row("=", 1'b0, KIND_ASSIGN, 16'd1, 16'd1);
        typed_row(8'h00, 1'b0, KIND_ERROR, 16'd1, 16'd2);
        typed_row(8'hFF, 1'b0, KIND_ERROR, 16'd1, 16'd3);
        typed_row(CH_POINT, 1'b0, KIND_ERROR, 16'd1, 16'd4);
        row(CH_NEWLINE);
        row("i");
        row("f");
        row("(");
        row("1");
        row("2");
        row(CH_POINT);
        row(" ");
        row(CH_SLASH);
        row(CH_SLASH);
        row("x");
        row(CH_NEWLINE);
        row(CH_SLASH);
        row("7");
        row(";");
        row("3");
        row(CH_POINT);
        row("5");
        row(CH_POINT);
        typed_row(8'hA5, 1'b1, KIND_EOF, 16'd3, 16'd8);

        compose_random_text();

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].tok);
        hold_off_req = 1'b1;
        foreach (source_text[i]) send_item(source_text[i], 1'b0, '0);
        i_valid <= 1'b0;

        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
